### rtl/jerk_limited_stop_profile_assert.svh
// Assertion macros shared by the stop profile RTL.
`ifndef JERK_LIMITED_STOP_PROFILE_ASSERT_SVH
`define JERK_LIMITED_STOP_PROFILE_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define JLSP_CHECK(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define JLSP_CHECK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/jlsp_pkg.sv
// Types, codes and constants of the jerk-limited stop profile generator.
`default_nettype none

package jlsp_pkg;

    // Default widths of the speed and point count registers.
    localparam int SPEED_BITS_DEF = 32;
    localparam int COUNT_BITS_DEF = 16;

    // Command codes of an input word.
    localparam logic CMD_START   = 1'b0;
    localparam logic CMD_ADVANCE = 1'b1;

    // Status codes of a result word.
    localparam logic [1:0] STAT_POINT = 2'd0;
    localparam logic [1:0] STAT_REST  = 2'd1;
    localparam logic [1:0] STAT_FAIL  = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_DECEL = 2'd0;
    localparam logic [1:0] CFG_JERK  = 2'd1;
    localparam logic [1:0] CFG_STEP  = 2'd2;
    localparam logic [1:0] CFG_CAP   = 2'd3;

    localparam int CFG_DATA_W = 31;

    typedef struct packed {
        logic              command;
        logic signed [31:0] initial_speed;
    } t_in_word;

    typedef struct packed {
        logic [1:0]         status;
        logic [39:0]        point_time;
        logic [30:0]        point_speed;
        logic signed [31:0] point_accel;
        logic signed [31:0] point_jerk;
        logic [47:0]        point_distance;
        logic [15:0]        point_index;
    } t_out_word;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_DA,
        S_VJ,
        S_AA,
        S_ACC,
        S_DV,
        S_SD
    } t_state;

    // Operand pairs of the shared multiplier.
    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_JT,
        MUL_VJ,
        MUL_AA,
        MUL_AT,
        MUL_ST
    } t_mul_sel;

    // Operands offered to the shared multiplier.
    typedef struct packed {
        logic [30:0] jerk;
        logic [15:0] step;
        logic [31:0] speed;
        logic [31:0] mag;
        logic [31:0] vsum;
    } t_mul_ops;

endpackage

`default_nettype wire

### rtl/jerk_limited_stop_profile.sv
// An advance word that emits a point steps through S_DA, S_VJ and S_AA (ramp-down branch
// only), S_ACC, which loads the output register, then S_DV and S_SD; rest and failure words
// are loaded on acceptance. One shared multiplier serves up to five dependent products, so
// no new word is accepted until the sequence is back in idle; other words leave it idle.
// Reset is synchronous and active low: control and profile registers take their reset
// values, the profile goes idle and the output register empties.
`default_nettype none

module jerk_limited_stop_profile #(
    parameter int SPEED_BITS = jlsp_pkg::SPEED_BITS_DEF,
    parameter int COUNT_BITS = jlsp_pkg::COUNT_BITS_DEF
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_in_valid,
    output logic                             o_in_ready,
    input  wire jlsp_pkg::t_in_word          i_in_word,
    output logic                             o_out_valid,
    input  wire                              i_out_ready,
    output jlsp_pkg::t_out_word              o_out_word,
    input  wire                              i_cfg_we,
    input  wire [1:0]                        i_cfg_idx,
    input  wire [jlsp_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    // Internal speed width: the start speed is at most 31 bits of magnitude.
    localparam int          SPD_W     = (SPEED_BITS > 32) ? 31 : SPEED_BITS - 1;
    localparam logic [31:0] SPEED_MAX = 32'((33'd1 << SPD_W) - 33'd1);
    localparam logic [31:0] COUNT_MAX = 32'((33'd1 << COUNT_BITS) - 33'd1);

    jlsp_pkg::t_state r_state, n_state;

    logic [30:0]            r_decel;
    logic [30:0]            r_jerk;
    logic [15:0]            r_step;
    logic [15:0]            r_cap;

    logic [39:0]            r_time;
    logic [SPD_W-1:0]       r_speed;
    logic signed [31:0]     r_accel;
    logic [47:0]            r_dist;
    logic [COUNT_BITS-1:0]  r_count;
    logic                   r_running;

    logic [30:0]            r_da;
    logic [61:0]            r_prod;
    logic                   r_down;
    logic [SPD_W-1:0]       r_nv;

    logic                   r_out_valid;
    jlsp_pkg::t_out_word    r_out;

    logic                   in_acc;
    logic                   is_adv;
    logic [31:0]            cap_eff;
    logic                   bad_cfg;
    logic                   cap_full;
    logic                   stop_now;
    logic                   out_load;
    logic [30:0]            start_spd;

    jlsp_pkg::t_mul_sel     mul_sel;
    jlsp_pkg::t_mul_ops     mul_ops;
    logic [63:0]            prod;

    logic signed [32:0]     a_ext;
    logic signed [32:0]     lim_neg;
    logic signed [32:0]     a_step;
    logic                   ramp_up;
    logic signed [31:0]     acc_new;
    logic signed [31:0]     jerk_new;

    logic [30:0]            dv;
    logic [30:0]            sp31;
    logic [30:0]            nv31;
    logic [30:0]            sd;
    logic [48:0]            dist_sum;

    // Handshake and stop conditions checked when a word is taken.
    assign in_acc    = i_in_valid && o_in_ready;
    assign is_adv    = (i_in_word.command == jlsp_pkg::CMD_ADVANCE);
    assign cap_eff   = (32'(r_cap) < COUNT_MAX) ? 32'(r_cap) : COUNT_MAX;
    assign bad_cfg   = (r_decel == '0) || (r_jerk == '0) || (r_step == '0);
    assign cap_full  = (32'(r_count) >= cap_eff);
    assign stop_now  = bad_cfg || cap_full || (r_speed == '0);
    assign start_spd = i_in_word.initial_speed[31] ? 31'd0 : i_in_word.initial_speed[30:0];

    assign out_load = (in_acc && is_adv && r_running && stop_now)
                    || (r_state == jlsp_pkg::S_ACC);

    // Shared multiplier operands.
    assign mul_ops.jerk  = r_jerk;
    assign mul_ops.step  = r_step;
    assign mul_ops.speed = 32'(r_speed);
    assign mul_ops.mag   = -r_accel;
    assign mul_ops.vsum  = 32'(r_speed) + 32'(r_nv);

    jlsp_mul u_mul (
        .i_sel  (mul_sel),
        .i_ops  (mul_ops),
        .o_prod (prod)
    );

    // Acceleration update: ramp toward the limit, or back toward zero once allowed.
    assign a_ext   = {r_accel[31], r_accel};
    assign lim_neg = -$signed({2'b00, r_decel});
    assign ramp_up = (a_ext > lim_neg);

    always_comb begin
        a_step   = a_ext;
        acc_new  = r_accel;
        jerk_new = '0;
        if (ramp_up) begin
            a_step = a_ext - $signed({2'b00, r_da});
            if (a_step < lim_neg) begin
                acc_new = lim_neg[31:0];
            end else begin
                acc_new  = a_step[31:0];
                jerk_new = -$signed({1'b0, r_jerk});
            end
        end else if (r_down) begin
            a_step = a_ext + $signed({2'b00, r_da});
            if (a_step > 33'sd0) begin
                acc_new = '0;
            end else begin
                acc_new  = a_step[31:0];
                jerk_new = $signed({1'b0, r_jerk});
            end
        end
    end

    // Speed and distance integration terms.
    assign dv       = prod[46:16];
    assign sp31     = 31'(r_speed);
    assign nv31     = (sp31 > dv) ? (sp31 - dv) : 31'd0;
    assign sd       = prod[47:17];
    assign dist_sum = {1'b0, r_dist} + 49'(sd);

    // Next state of the sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            jlsp_pkg::S_IDLE: begin
                if (in_acc && is_adv && r_running && !stop_now) begin
                    n_state = jlsp_pkg::S_DA;
                end
            end
            jlsp_pkg::S_DA:  n_state = ramp_up ? jlsp_pkg::S_ACC : jlsp_pkg::S_VJ;
            jlsp_pkg::S_VJ:  n_state = jlsp_pkg::S_AA;
            jlsp_pkg::S_AA:  n_state = jlsp_pkg::S_ACC;
            jlsp_pkg::S_ACC: n_state = jlsp_pkg::S_DV;
            jlsp_pkg::S_DV:  n_state = jlsp_pkg::S_SD;
            jlsp_pkg::S_SD:  n_state = jlsp_pkg::S_IDLE;
            default:         n_state = jlsp_pkg::S_IDLE;
        endcase
    end

    // Sequencer outputs: input ready and multiplier operand choice.
    always_comb begin
        o_in_ready = 1'b0;
        mul_sel    = jlsp_pkg::MUL_NONE;
        unique case (r_state)
            jlsp_pkg::S_IDLE: o_in_ready = !r_out_valid || i_out_ready;
            jlsp_pkg::S_DA:   mul_sel = jlsp_pkg::MUL_JT;
            jlsp_pkg::S_VJ:   mul_sel = jlsp_pkg::MUL_VJ;
            jlsp_pkg::S_AA:   mul_sel = jlsp_pkg::MUL_AA;
            jlsp_pkg::S_ACC:  mul_sel = jlsp_pkg::MUL_NONE;
            jlsp_pkg::S_DV:   mul_sel = jlsp_pkg::MUL_AT;
            jlsp_pkg::S_SD:   mul_sel = jlsp_pkg::MUL_ST;
            default:          mul_sel = jlsp_pkg::MUL_NONE;
        endcase
    end

    // Control and profile state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= jlsp_pkg::S_IDLE;
            r_decel     <= 31'd327680;
            r_jerk      <= 31'd655360;
            r_step      <= 16'd655;
            r_cap       <= 16'd1024;
            r_time      <= '0;
            r_speed     <= '0;
            r_accel     <= '0;
            r_dist      <= '0;
            r_count     <= '0;
            r_running   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= out_load || (r_out_valid && !i_out_ready);

            // Configuration writes.
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    jlsp_pkg::CFG_DECEL: r_decel <= i_cfg_data;
                    jlsp_pkg::CFG_JERK:  r_jerk  <= i_cfg_data;
                    jlsp_pkg::CFG_STEP:  r_step  <= i_cfg_data[15:0];
                    jlsp_pkg::CFG_CAP:   r_cap   <= i_cfg_data[15:0];
                    default: ;
                endcase
            end

            // Start word: load speed and clear the profile; advance that ends it.
            if (in_acc) begin
                if (!is_adv) begin
                    r_speed   <= (32'(start_spd) > SPEED_MAX) ? SPD_W'(SPEED_MAX)
                                                             : SPD_W'(start_spd);
                    r_time    <= '0;
                    r_accel   <= '0;
                    r_dist    <= '0;
                    r_count   <= '0;
                    r_running <= 1'b1;
                end else if (r_running && stop_now) begin
                    r_running <= 1'b0;
                end
            end

            if (r_state == jlsp_pkg::S_ACC) begin
                r_accel <= acc_new;
                r_count <= r_count + 1'b1;
            end

            // Integrate time, distance and speed.
            if (r_state == jlsp_pkg::S_SD) begin
                r_time  <= r_time + 40'(r_step);
                r_dist  <= dist_sum[48] ? '1 : dist_sum[47:0];
                r_speed <= r_nv;
            end
        end
    end

    // Working registers of the multiply sequence.
    always_ff @(posedge i_clk) begin
        if (r_state == jlsp_pkg::S_DA) begin
            r_da   <= prod[46:16];
            r_down <= 1'b0;
        end
        if (r_state == jlsp_pkg::S_VJ) begin
            r_prod <= prod[61:0];
        end
        if (r_state == jlsp_pkg::S_AA) begin
            r_down <= (r_prod <= prod[61:0]);
        end
        if (r_state == jlsp_pkg::S_DV) begin
            r_nv <= SPD_W'(nv31);
        end
    end

    // Output word register.
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out.point_time     <= r_time;
            r_out.point_distance <= r_dist;
            r_out.point_index    <= 16'(r_count);
            if (r_state == jlsp_pkg::S_ACC) begin
                r_out.status      <= jlsp_pkg::STAT_POINT;
                r_out.point_speed <= 31'(r_speed);
                r_out.point_accel <= acc_new;
                r_out.point_jerk  <= jerk_new;
            end else if (bad_cfg || cap_full) begin
                r_out.status      <= jlsp_pkg::STAT_FAIL;
                r_out.point_speed <= 31'(r_speed);
                r_out.point_accel <= r_accel;
                r_out.point_jerk  <= '0;
            end else begin
                r_out.status      <= jlsp_pkg::STAT_REST;
                r_out.point_speed <= '0;
                r_out.point_accel <= '0;
                r_out.point_jerk  <= '0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    // Design checks.
    `include "jerk_limited_stop_profile_assert.svh"

    `JLSP_CHECK(a_busy_not_ready, i_clk, i_rst_n, r_state != jlsp_pkg::S_IDLE, !o_in_ready, "input ready while sequence runs")
    `JLSP_CHECK(a_no_overwrite, i_clk, i_rst_n, r_out_valid && !i_out_ready, !out_load, "output word overwritten before it was taken")
    `JLSP_CHECK(a_accel_nonpos, i_clk, i_rst_n, 1'b1, r_accel[31] || (r_accel == '0), "acceleration became positive")
    `JLSP_CHECK(a_seq_from_accept, i_clk, i_rst_n, r_state == jlsp_pkg::S_DA, $past(in_acc), "multiply sequence started without an accepted word")
    `JLSP_CHECK_NEXT(a_speed_falls, i_clk, i_rst_n, r_state == jlsp_pkg::S_SD, r_speed <= $past(r_speed), "speed rose during integration")

endmodule

`default_nettype wire

### rtl/jlsp_mul.sv
// Shared 32x32 unsigned multiplier with its operand selection.
`default_nettype none

module jlsp_mul (
    input  wire jlsp_pkg::t_mul_sel i_sel,
    input  wire jlsp_pkg::t_mul_ops i_ops,
    output logic [63:0]             o_prod
);

    logic [31:0] op_a;
    logic [31:0] op_b;

    // Pick the operand pair for the current sequencer step.
    always_comb begin
        unique case (i_sel)
            jlsp_pkg::MUL_JT: begin
                op_a = 32'(i_ops.jerk);
                op_b = 32'(i_ops.step);
            end
            jlsp_pkg::MUL_VJ: begin
                op_a = i_ops.speed;
                op_b = 32'(i_ops.jerk);
            end
            jlsp_pkg::MUL_AA: begin
                op_a = i_ops.mag;
                op_b = i_ops.mag;
            end
            jlsp_pkg::MUL_AT: begin
                op_a = i_ops.mag;
                op_b = 32'(i_ops.step);
            end
            jlsp_pkg::MUL_ST: begin
                op_a = i_ops.vsum;
                op_b = 32'(i_ops.step);
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    assign o_prod = 64'(op_a) * 64'(op_b);

endmodule

`default_nettype wire

### verif/tb_top.sv
// Self-checking testbench of the stop profile generator: directed table, then random words.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          RANDOM_WORDS = 1025;
    localparam int          DRAIN_CYCLES = 12;
    localparam int unsigned CYCLE_LIMIT  = 400000;

    // Kinds of rows in the directed table.
    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_QUIET,
        ROW_PRED,
        ROW_TYPED
    } t_row_kind;

    typedef struct packed {
        t_row_kind           kind;
        logic                command;
        logic [31:0]         speed;
        logic [1:0]          reg_idx;
        logic [30:0]         reg_val;
        jlsp_pkg::t_out_word typed;
    } t_row;

    // Typed points that follow directly from the rules for rest and failure.
    localparam jlsp_pkg::t_out_word REST_AT_ZERO =
        '{jlsp_pkg::STAT_REST, 40'd0, 31'd0, 32'sd0, 32'sd0, 48'd0, 16'd0};
    localparam jlsp_pkg::t_out_word FAIL_ONE_MPS =
        '{jlsp_pkg::STAT_FAIL, 40'd0, 31'd65536, 32'sd0, 32'sd0, 48'd0, 16'd0};
    localparam jlsp_pkg::t_out_word FAIL_FIVE_MPS =
        '{jlsp_pkg::STAT_FAIL, 40'd0, 31'd327680, 32'sd0, 32'sd0, 48'd0, 16'd0};

    // Directed table: idle advances, clamped starts, extremes, restarts, capacity and zero registers.
    localparam int N_DIRECTED = 37;
    localparam t_row DIRECTED [N_DIRECTED] = '{
        '{ROW_QUIET, jlsp_pkg::CMD_ADVANCE, 32'h0000_0000, jlsp_pkg::CFG_DECEL, 31'd0, '0},
        '{ROW_QUIET, jlsp_pkg::CMD_START,   32'h0000_0000, jlsp_pkg::CFG_DECEL, 31'd0, '0},
        '{ROW_TYPED, jlsp_pkg::CMD_ADVANCE, 32'h0000_0000, jlsp_pkg::CFG_DECEL, 31'd0,
          REST_AT_ZERO},
        '{ROW_QUIET, jlsp_pkg::CMD_START,   32'h8000_0000, jlsp_pkg::CFG_DECEL, 31'd0, '0},
        '{ROW_TYPED, jlsp_pkg::CMD_ADVANCE, 32'h0000_0000, jlsp_pkg::CFG_DECEL, 31'd0,
          REST_AT_ZERO},
        '{ROW_PRED,  jlsp_pkg::CMD_START,   32'h0000_0001, jlsp_pkg::CFG_DECEL, 31'd0, '0},
        '{ROW_PRED,  jlsp_pkg::CMD_ADVANCE, 32'h0000_0000, jlsp_pkg::CFG_DECEL, 31'd0, '0},
        '{ROW_PRED,  jlsp_pkg::CMD_ADVANCE, 32'h0000_0000, jlsp_pkg::CFG_DECEL, 31'd0, '0},
        '{ROW_PRED,  jlsp_pkg::CMD_START,   32'h7FFF_FFFF, jlsp_pkg::CFG_DECEL, 31'd0, '0},
        '{ROW_PRED,  jlsp_pkg::CMD_ADVANCE, 32'h0000_0000, jlsp_pkg::CFG_DECEL, 31'd0, '0},
        '{ROW_PRED,  jlsp_pkg::CMD_ADVANCE, 32'h0000_0000, jlsp_pkg::CFG_DECEL, 31'd0, '0},
        '{ROW_PRED,  jlsp_pkg::CMD_START,   32'h0003_0000, jlsp_pkg::CFG_DECEL, 31'd0, '0},
        '{ROW_PRED,  jlsp_pkg::CMD_ADVANCE, 32'h0000_0000, jlsp_pkg::CFG_DECEL, 31'd0, '0},
        '{ROW_CFG,   jlsp_pkg::CMD_START,   32'h0000_0000, jlsp_pkg::CFG_CAP,   31'd1, '0},
        '{ROW_PRED,  jlsp_pkg::CMD_START,   32'h7FFF_FFFF, jlsp_pkg::CFG_DECEL, 31'd0, '0},
        '{ROW_PRED,  jlsp_pkg::CMD_ADVANCE, 32'h0000_0000, jlsp_pkg::CFG_DECEL, 31'd0, '0},
        '{ROW_PRED,  jlsp_pkg::CMD_ADVANCE, 32'h0000_0000, jlsp_pkg::CFG_DECEL, 31'd0, '0},
        '{ROW_CFG,   jlsp_pkg::CMD_START,   32'h0000_0000, jlsp_pkg::CFG_CAP,   31'd0, '0},
        '{ROW_PRED,  jlsp_pkg::CMD_START,   32'h0005_0000, jlsp_pkg::CFG_DECEL, 31'd0, '0},
        '{ROW_TYPED, jlsp_pkg::CMD_ADVANCE, 32'h0000_0000, jlsp_pkg::CFG_DECEL, 31'd0,
          FAIL_FIVE_MPS},
        '{ROW_CFG,   jlsp_pkg::CMD_START,   32'h0000_0000, jlsp_pkg::CFG_CAP,   31'd1024, '0},
        '{ROW_CFG,   jlsp_pkg::CMD_START,   32'h0000_0000, jlsp_pkg::CFG_DECEL, 31'd0, '0},
        '{ROW_PRED,  jlsp_pkg::CMD_START,   32'h0001_0000, jlsp_pkg::CFG_DECEL, 31'd0, '0},
        '{ROW_TYPED, jlsp_pkg::CMD_ADVANCE, 32'h0000_0000, jlsp_pkg::CFG_DECEL, 31'd0,
          FAIL_ONE_MPS},
        '{ROW_CFG,   jlsp_pkg::CMD_START,   32'h0000_0000, jlsp_pkg::CFG_DECEL,
          31'h7FFF_FFFF, '0},
        '{ROW_CFG,   jlsp_pkg::CMD_START,   32'h0000_0000, jlsp_pkg::CFG_JERK,  31'd0, '0},
        '{ROW_PRED,  jlsp_pkg::CMD_START,   32'h0001_0000, jlsp_pkg::CFG_DECEL, 31'd0, '0},
        '{ROW_TYPED, jlsp_pkg::CMD_ADVANCE, 32'h0000_0000, jlsp_pkg::CFG_DECEL, 31'd0,
          FAIL_ONE_MPS},
        '{ROW_CFG,   jlsp_pkg::CMD_START,   32'h0000_0000, jlsp_pkg::CFG_JERK,
          31'h7FFF_FFFF, '0},
        '{ROW_CFG,   jlsp_pkg::CMD_START,   32'h0000_0000, jlsp_pkg::CFG_STEP,  31'd0, '0},
        '{ROW_PRED,  jlsp_pkg::CMD_START,   32'h0001_0000, jlsp_pkg::CFG_DECEL, 31'd0, '0},
        '{ROW_TYPED, jlsp_pkg::CMD_ADVANCE, 32'h0000_0000, jlsp_pkg::CFG_DECEL, 31'd0,
          FAIL_ONE_MPS},
        '{ROW_CFG,   jlsp_pkg::CMD_START,   32'h0000_0000, jlsp_pkg::CFG_STEP,
          31'h0000_FFFF, '0},
        '{ROW_PRED,  jlsp_pkg::CMD_START,   32'h7FFF_FFFF, jlsp_pkg::CFG_DECEL, 31'd0, '0},
        '{ROW_PRED,  jlsp_pkg::CMD_ADVANCE, 32'h0000_0000, jlsp_pkg::CFG_DECEL, 31'd0, '0},
        '{ROW_PRED,  jlsp_pkg::CMD_ADVANCE, 32'h0000_0000, jlsp_pkg::CFG_DECEL, 31'd0, '0},
        '{ROW_PRED,  jlsp_pkg::CMD_ADVANCE, 32'h0000_0000, jlsp_pkg::CFG_DECEL, 31'd0, '0}
    };

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    jlsp_pkg::t_in_word  i_in_word   = '0;
    logic                i_out_ready = 1'b0;
    logic                i_cfg_we    = 1'b0;
    logic [1:0]          i_cfg_idx   = jlsp_pkg::CFG_DECEL;
    logic [30:0]         i_cfg_data  = '0;
    logic                o_in_ready;
    logic                o_out_valid;
    jlsp_pkg::t_out_word o_out_word;

    // Register copies and profile state of the predictor.
    logic [30:0] cfg_decel    = 31'd327680;
    logic [30:0] cfg_jerk     = 31'd655360;
    logic [15:0] cfg_step     = 16'd655;
    logic [15:0] cfg_cap      = 16'd1024;
    logic [39:0] prof_time    = '0;
    logic [31:0] prof_speed   = '0;
    longint      prof_accel   = 0;
    logic [47:0] prof_dist    = '0;
    logic [15:0] prof_count   = '0;
    bit          prof_running = 1'b0;

    jlsp_pkg::t_out_word pending_points [$];
    int                  mismatch_count = 0;
    int                  burst_left     = 0;
    int unsigned         cycle_count    = 0;
    logic [1:0]          ready_mode     = 2'd0;

    jerk_limited_stop_profile dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Advances the predicted profile by one word; returns 1 when the word yields a point.
    function automatic bit next_profile_point(input jlsp_pkg::t_in_word w,
                                              output jlsp_pkg::t_out_word pt);
        longint jlim, dlim, tsi, spd, acc, jrk, da, dv, nv, sd, mag, dsum;
        pt = '0;
        if (w.command == jlsp_pkg::CMD_START) begin
            prof_speed   = w.initial_speed[31] ? 32'd0 : 32'(w.initial_speed);
            prof_time    = '0;
            prof_accel   = 0;
            prof_dist    = '0;
            prof_count   = '0;
            prof_running = 1'b1;
            return 1'b0;
        end
        if (!prof_running) return 1'b0;

        pt.point_time     = prof_time;
        pt.point_distance = prof_dist;
        pt.point_index    = prof_count;

        // A zero register or a full profile ends it with the current speed and acceleration.
        if (cfg_decel == 0 || cfg_jerk == 0 || cfg_step == 0 || prof_count >= cfg_cap) begin
            pt.status      = jlsp_pkg::STAT_FAIL;
            pt.point_speed = prof_speed[30:0];
            pt.point_accel = prof_accel[31:0];
            prof_running   = 1'b0;
            return 1'b1;
        end
        if (prof_speed == 0) begin
            pt.status    = jlsp_pkg::STAT_REST;
            prof_running = 1'b0;
            return 1'b1;
        end

        jlim = longint'(cfg_jerk);
        dlim = longint'(cfg_decel);
        tsi  = longint'(cfg_step);
        spd  = longint'(prof_speed);
        da   = (jlim * tsi) >> 16;
        acc  = prof_accel;

        // Build deceleration up to the limit, then release it once speed is low enough.
        if (acc > -dlim) begin
            jrk = -jlim;
            acc = acc - da;
            if (acc < -dlim) begin
                acc = -dlim;
                jrk = 0;
            end
        end else begin
            mag = -acc;
            if (spd * jlim <= mag * mag) begin
                jrk = jlim;
                acc = acc + da;
                if (acc > 0) begin
                    acc = 0;
                    jrk = 0;
                end
            end else begin
                jrk = 0;
            end
        end
        prof_accel = acc;

        pt.status      = jlsp_pkg::STAT_POINT;
        pt.point_speed = spd[30:0];
        pt.point_accel = acc[31:0];
        pt.point_jerk  = jrk[31:0];
        prof_count     = prof_count + 16'd1;

        // Integrate speed, clamped at zero, and trapezoidal distance, saturated at 48 bits.
        dv   = (-acc * tsi) >> 16;
        nv   = (spd > dv) ? spd - dv : 0;
        sd   = ((spd + nv) * tsi) >> 17;
        dsum = longint'(prof_dist) + sd;
        prof_time  = prof_time + 40'(cfg_step);
        prof_dist  = (dsum > 64'hFFFF_FFFF_FFFF) ? '1 : dsum[47:0];
        prof_speed = nv[31:0];
        return 1'b1;
    endfunction

    // Offers one word, waits for its acceptance, records the expected point and maybe idles.
    task automatic send_word(input logic cmd, input logic [31:0] speed,
                             input t_row_kind kind, input jlsp_pkg::t_out_word typed);
        jlsp_pkg::t_in_word  w;
        jlsp_pkg::t_out_word pt;
        bit                  has_pt;
        w.command       = cmd;
        w.initial_speed = speed;
        i_in_word  <= w;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        has_pt = next_profile_point(w, pt);
        if (kind == ROW_TYPED) pending_points.push_back(typed);
        else if (kind == ROW_PRED && has_pt) pending_points.push_back(pt);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 6);
        end
    endtask

    // Waits until every expected point has arrived and the block has had time to settle.
    task automatic drain_points();
        i_in_valid <= 1'b0;
        while (pending_points.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Writes one register and keeps the predictor's copy in step.
    task automatic write_reg(input logic [1:0] idx, input logic [30:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            jlsp_pkg::CFG_DECEL: cfg_decel = val;
            jlsp_pkg::CFG_JERK:  cfg_jerk  = val;
            jlsp_pkg::CFG_STEP:  cfg_step  = val[15:0];
            jlsp_pkg::CFG_CAP:   cfg_cap   = val[15:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // Deceleration and jerk limits: extremes, zero now and then, and realistic ranges.
    function automatic logic [30:0] pick_limit();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return 31'd0;
        if (r <= 2) return 31'd1;
        if (r <= 4) return 31'h7FFF_FFFF;
        if (r <= 9) return 31'($urandom_range(32'h0000_8000, 32'h0010_0000));
        return 31'($urandom_range(32'h0001_0000, 32'h0200_0000));
    endfunction

    function automatic logic [30:0] pick_step();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return 31'd0;
        if (r <= 2) return 31'd1;
        if (r <= 4) return 31'h0000_FFFF;
        if (r <= 9) return 31'($urandom_range(200, 2000));
        return 31'($urandom_range(2000, 65535));
    endfunction

    // Capacities are mostly small so that many profiles end within a phase.
    function automatic logic [30:0] pick_cap();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return 31'd0;
        if (r == 1) return 31'd1;
        if (r == 2) return 31'h0000_FFFF;
        if (r <= 4) return 31'd1024;
        if (r <= 14) return 31'($urandom_range(2, 40));
        return 31'($urandom_range(41, 300));
    endfunction

    function automatic logic [31:0] pick_speed();
        int r;
        r = $urandom_range(0, 19);
        if (r <= 1) return 32'd0;
        if (r <= 3) return $urandom | 32'h8000_0000;
        if (r <= 5) return $urandom_range(1, 255);
        if (r == 6) return 32'h7FFF_FFFF;
        if (r <= 14) return $urandom_range(1, 32'h000A_0000);
        return $urandom & 32'h7FFF_FFFF;
    endfunction

    // Compares one field of a result word and reports the first few differences.
    task automatic check_field(input string name, input logic [15:0] index,
                               input logic [63:0] want, input logic [63:0] got);
        if (want !== got) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("point %0d field %s: expected %0h, got %0h",
                         index, name, want, got);
        end
    endtask

    // Checks each accepted result word against the oldest expected point.
    always @(posedge i_clk) begin : point_checker
        jlsp_pkg::t_out_word want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) begin
            if (pending_points.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result word %0h", o_out_word);
            end else begin
                want = pending_points.pop_front();
                check_field("status", want.point_index, 64'(want.status),
                            64'(o_out_word.status));
                check_field("point_time", want.point_index, 64'(want.point_time),
                            64'(o_out_word.point_time));
                check_field("point_speed", want.point_index, 64'(want.point_speed),
                            64'(o_out_word.point_speed));
                check_field("point_accel", want.point_index, 64'(want.point_accel),
                            64'(o_out_word.point_accel));
                check_field("point_jerk", want.point_index, 64'(want.point_jerk),
                            64'(o_out_word.point_jerk));
                check_field("point_distance", want.point_index, 64'(want.point_distance),
                            64'(o_out_word.point_distance));
                check_field("point_index", want.point_index, 64'(want.point_index),
                            64'(o_out_word.point_index));
            end
        end
    end

    // Receiver: switches between always ready, random, sparse and periodic stalls.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count[7:0] == 8'd0) ready_mode <= 2'($urandom_range(0, 3));
        case (ready_mode)
            2'd0:    i_out_ready <= 1'b1;
            2'd1:    i_out_ready <= 1'($urandom_range(0, 1));
            2'd2:    i_out_ready <= ($urandom_range(0, 5) == 0);
            default: i_out_ready <= (cycle_count[2:0] < 3'd3);
        endcase
    end

    // Watchdog on the whole run.
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    // Reset, directed table, random phases, then the final verdict.
    initial begin : stimulus
        t_row row;
        int   n;
        int   phase_len;
        int   counted;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (n = 0; n < N_DIRECTED; n++) begin
            row = DIRECTED[n];
            if (row.kind == ROW_CFG) begin
                drain_points();
                write_reg(row.reg_idx, row.reg_val);
            end else begin
                send_word(row.command, row.speed, row.kind, row.typed);
            end
        end

        // Each phase runs profiles under a fresh register setting, with some restarts.
        counted = 0;
        while (counted < RANDOM_WORDS) begin
            drain_points();
            write_reg(jlsp_pkg::CFG_DECEL, pick_limit());
            write_reg(jlsp_pkg::CFG_JERK, pick_limit());
            write_reg(jlsp_pkg::CFG_STEP, pick_step());
            write_reg(jlsp_pkg::CFG_CAP, pick_cap());
            phase_len = $urandom_range(40, 120);
            n = 0;
            while (n < phase_len && counted < RANDOM_WORDS) begin
                if (!prof_running && $urandom_range(0, 15) == 0) begin
                    // An advance while idle is dropped by the block.
                    send_word(jlsp_pkg::CMD_ADVANCE, $urandom, ROW_PRED, '0);
                end else begin
                    if (!prof_running || $urandom_range(0, 49) == 0)
                        send_word(jlsp_pkg::CMD_START, pick_speed(), ROW_PRED, '0);
                    else
                        send_word(jlsp_pkg::CMD_ADVANCE, $urandom, ROW_PRED, '0);
                    n++;
                    counted++;
                end
            end
        end

        drain_points();
        if (mismatch_count == 0 && pending_points.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl
rtl/jlsp_pkg.sv
rtl/jlsp_mul.sv
rtl/jerk_limited_stop_profile.sv
verif/tb_top.sv
